@@ hdl/assert_macros.svh @@
// Assertion helpers used by the top-level normalizer RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition implies the expression in the same cycle.
`define USN_ASSERT_IMPLY(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// The condition implies the expression in the next cycle.
`define USN_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

@@ hdl/usn_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package usn_pkg;

   localparam int QueueDepth = 4;
   localparam int EntryMax   = 3;
   localparam int BurstMax   = 6;
   localparam int ResultCap  = 6;

   localparam logic [7:0] SeqByte0  = 8'hE2;
   localparam logic [7:0] SeqByte1  = 8'h96;
   localparam logic [7:0] SeqByte2  = 8'h81;
   localparam logic [7:0] SpaceByte = 8'h20;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       text_end;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       end_of_text;
   } rsp_payload_type;

   typedef struct packed {
      logic [EntryMax-1:0][7:0] data;
      logic [1:0]               count;
      logic                     text_end;
   } dec_entry_type;

   typedef struct packed {
      logic [BurstMax-1:0][7:0] data;
      logic [2:0]               count;
      logic                     bare;
      logic                     eot;
   } burst_type;

endpackage

`default_nettype wire

@@ hdl/usn_stream_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface usn_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ hdl/usn_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module usn_fifo #(
   parameter int Depth = usn_pkg::QueueDepth
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  usn_pkg::dec_entry_type push_data,
   output logic                   full,
   input  logic                   pop,
   output usn_pkg::dec_entry_type pop_data,
   output logic                   not_empty
);
   import usn_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   dec_entry_type   slot_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff;
   logic [PtrW-1:0] wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff;
   logic [PtrW-1:0] rd_ptr_in;
   logic [CntW-1:0] count_ff;
   logic [CntW-1:0] count_in;

   assign full      = count_ff == CntW'(Depth);
   assign not_empty = count_ff != '0;
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ hdl/usn_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module usn_front (
   input  logic                   clock,
   input  logic                   reset,
   usn_stream_if.sink             req_chan,
   input  logic                   queue_full,
   output logic                   push,
   output usn_pkg::dec_entry_type entry
);
   import usn_pkg::*;

   logic [1:0] held_ff;
   logic [1:0] held_in;
   logic       accept;
   logic       has_bytes;
   logic       fresh_hold;
   logic [7:0] in_byte;
   logic       at_end;

   assign req_chan.ready = !queue_full;
   assign accept         = req_chan.valid && req_chan.ready;
   assign push           = accept && has_bytes;
   assign in_byte        = req_chan.payload.in_byte;
   assign at_end         = req_chan.payload.text_end;

   // The held bytes are always a prefix of the space mark, so only the count is kept.
   always_comb begin
      fresh_hold     = (in_byte == SeqByte0) && !at_end;
      entry          = '0;
      entry.text_end = at_end;
      held_in        = 2'd0;
      has_bytes      = 1'b1;
      case (held_ff)
         2'd1: begin
            if (in_byte == SeqByte1 && !at_end) begin
               held_in   = 2'd2;
               has_bytes = 1'b0;
            end else if (fresh_hold) begin
               entry.data[0] = SeqByte0;
               entry.count   = 2'd1;
               held_in       = 2'd1;
            end else begin
               entry.data[0] = SeqByte0;
               entry.data[1] = in_byte;
               entry.count   = 2'd2;
            end
         end
         2'd2: begin
            if (in_byte == SeqByte2) begin
               entry.data[0] = SpaceByte;
               entry.count   = 2'd1;
            end else begin
               entry.data[0] = SeqByte0;
               entry.data[1] = SeqByte1;
               if (fresh_hold) begin
                  entry.count = 2'd2;
                  held_in     = 2'd1;
               end else begin
                  entry.data[2] = in_byte;
                  entry.count   = 2'd3;
               end
            end
         end
         default: begin
            if (fresh_hold) begin
               held_in   = 2'd1;
               has_bytes = 1'b0;
            end else begin
               entry.data[0] = in_byte;
               entry.count   = 2'd1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 2'd0;
      end else if (accept) begin
         held_ff <= held_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/usn_decode.sv @@
`timescale 1ns / 1ps
`default_nettype none

module usn_decode (
   input  logic                   clock,
   input  logic                   reset,
   input  usn_pkg::dec_entry_type entry,
   input  logic                   entry_valid,
   output logic                   entry_pop,
   input  logic                   emit_free,
   output logic                   burst_valid,
   output usn_pkg::burst_type     burst
);
   import usn_pkg::*;

   typedef enum logic [1:0] {ActNone, ActDeliver, ActHead, ActTail} act_type;

   localparam logic [20:0] HeadLimit = 21'h400;

   function automatic logic is_cjk(input logic [20:0] c);
      is_cjk = (c >= 21'h3400 && c <= 21'h4DBF) || (c >= 21'h4E00 && c <= 21'h9FFF) ||
               (c >= 21'hF900 && c <= 21'hFAFF) || (c >= 21'h3000 && c <= 21'h303F) ||
               (c >= 21'hFF00 && c <= 21'hFFEF);
   endfunction

   // Comma, period, exclamation and question marks, semicolon, colon, percent
   // and the three closing brackets.
   function automatic logic is_punct(input logic [20:0] c);
      is_punct = c inside {21'h2C, 21'h2E, 21'h21, 21'h3F, 21'h3B,
                           21'h3A, 21'h25, 21'h29, 21'h5D, 21'h7D};
   endfunction

   logic [20:0]      partial_ff;
   logic [20:0]      partial_in;
   logic [1:0]       rem_ff;
   logic [1:0]       rem_in;
   logic             head_sent_ff;
   logic             head_sent_in;
   logic             space_pend_ff;
   logic             space_pend_in;
   logic             last_valid_ff;
   logic             last_valid_in;
   logic             last_cjk_ff;
   logic             last_cjk_in;
   logic [7:0]       tail_ff;
   logic [7:0]       tail_in;
   logic             tail_valid_ff;
   logic             tail_valid_in;
   logic [2:0]       item_cnt_ff;
   logic [1:0]       sidx_ff;

   logic             step_go;
   logic [7:0]       cur_byte;
   logic             at_end;
   logic             last_step;
   logic             final_step;
   logic [20:0]      cont_code;
   act_type          act;
   logic [20:0]      code;
   logic             code_cjk;
   logic             gate;
   logic [3:0][7:0]  enc;
   logic [2:0]       enc_n;
   logic [3:0][7:0]  body;
   logic [2:0]       body_n;
   logic [4:0][7:0]  lst;
   logic [2:0]       n_list;
   logic [2:0]       room;
   logic [2:0]       n_cap;
   logic [5:0][7:0]  merged;
   logic [2:0]       n_merged;

   assign step_go    = entry_valid && emit_free;
   assign cur_byte   = entry.data[sidx_ff];
   assign at_end     = entry.text_end;
   assign last_step  = sidx_ff == (entry.count - 2'd1);
   assign final_step = at_end && last_step;
   assign entry_pop  = step_go && last_step;
   assign cont_code  = {partial_ff[14:0], cur_byte[5:0]};

   // Byte decode: lead classes, continuation assembly, early head and end flush.
   always_comb begin
      act          = ActNone;
      code         = '0;
      partial_in   = partial_ff;
      rem_in       = rem_ff;
      head_sent_in = head_sent_ff;
      if (rem_ff == 2'd0) begin
         if (!cur_byte[7]) begin
            act  = ActDeliver;
            code = {13'd0, cur_byte};
         end else if (cur_byte[7:5] == 3'b110) begin
            partial_in = {16'd0, cur_byte[4:0]};
            rem_in     = 2'd1;
         end else if (cur_byte[7:4] == 4'b1110) begin
            partial_in = {17'd0, cur_byte[3:0]};
            rem_in     = 2'd2;
         end else begin
            partial_in = {18'd0, cur_byte[2:0]};
            rem_in     = 2'd3;
         end
      end else begin
         rem_in     = rem_ff - 2'd1;
         partial_in = cont_code;
         if (rem_ff == 2'd1) begin
            partial_in = '0;
            code       = cont_code;
            if (head_sent_ff) begin
               act          = ActTail;
               head_sent_in = 1'b0;
            end else begin
               act = ActDeliver;
            end
         end else if (rem_ff == 2'd2 && cont_code >= HeadLimit && !at_end) begin
            // The finished code point will be at least 0x10000, so its first
            // three bytes are already known.
            act          = ActHead;
            code         = {cont_code[14:0], 6'd0};
            head_sent_in = 1'b1;
         end
      end
      if (final_step && rem_in != 2'd0 && !head_sent_in) begin
         act  = ActDeliver;
         code = partial_in;
      end
   end

   always_comb begin
      enc   = '0;
      enc_n = 3'd1;
      if (code < 21'h80) begin
         enc[0] = code[7:0];
      end else if (code < 21'h800) begin
         enc[0] = {3'b110, code[10:6]};
         enc[1] = {2'b10, code[5:0]};
         enc_n  = 3'd2;
      end else if (code < 21'h10000) begin
         enc[0] = {4'b1110, code[15:12]};
         enc[1] = {2'b10, code[11:6]};
         enc[2] = {2'b10, code[5:0]};
         enc_n  = 3'd3;
      end else begin
         enc[0] = {5'b11110, code[20:18]};
         enc[1] = {2'b10, code[17:12]};
         enc[2] = {2'b10, code[11:6]};
         enc[3] = {2'b10, code[5:0]};
         enc_n  = 3'd4;
      end
   end

   // Space gate and the list of bytes that this step writes.
   always_comb begin
      code_cjk      = is_cjk(code);
      gate          = 1'b0;
      space_pend_in = space_pend_ff;
      last_valid_in = last_valid_ff;
      last_cjk_in   = last_cjk_ff;
      body          = '0;
      body_n        = 3'd0;
      case (act)
         ActDeliver: begin
            if (code == {13'd0, SpaceByte}) begin
               space_pend_in = 1'b1;
            end else begin
               gate = space_pend_ff && last_valid_ff && code != '0 &&
                      !(last_cjk_ff && code_cjk) && !is_punct(code);
               space_pend_in = 1'b0;
               body          = enc;
               body_n        = enc_n;
               last_valid_in = code != '0;
               last_cjk_in   = code_cjk;
            end
         end
         ActHead: begin
            gate          = space_pend_ff && last_valid_ff;
            space_pend_in = 1'b0;
            body          = enc;
            body_n        = 3'd3;
         end
         ActTail: begin
            body          = {24'd0, 2'b10, cur_byte[5:0]};
            body_n        = 3'd1;
            last_valid_in = code != '0;
            last_cjk_in   = code_cjk;
         end
         default: begin
         end
      endcase
      if (gate) begin
         lst    = {body, SpaceByte};
         n_list = body_n + 3'd1;
      end else begin
         lst    = {8'h00, body};
         n_list = body_n;
      end
   end

   // Within a text-end item the last byte so far is kept back, so that the end
   // mark can land on it if later steps write nothing.
   always_comb begin
      room          = 3'(ResultCap) - item_cnt_ff;
      n_cap         = (n_list > room) ? room : n_list;
      merged        = tail_valid_ff ? {lst, tail_ff} : {8'h00, lst};
      n_merged      = n_cap + {2'd0, tail_valid_ff};
      burst.data    = merged;
      burst.count   = n_merged;
      burst.bare    = 1'b0;
      burst.eot     = 1'b0;
      burst_valid   = 1'b0;
      tail_in       = tail_ff;
      tail_valid_in = tail_valid_ff;
      if (step_go) begin
         if (!at_end) begin
            burst_valid = n_merged != 3'd0;
         end else if (!last_step) begin
            if (n_merged != 3'd0) begin
               burst.count   = n_merged - 3'd1;
               burst_valid   = n_merged > 3'd1;
               tail_in       = merged[n_merged - 3'd1];
               tail_valid_in = 1'b1;
            end
         end else begin
            burst_valid   = 1'b1;
            burst.eot     = 1'b1;
            tail_valid_in = 1'b0;
            if (n_merged == 3'd0) begin
               burst.bare  = 1'b1;
               burst.count = 3'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff    <= '0;
         rem_ff        <= 2'd0;
         head_sent_ff  <= 1'b0;
         space_pend_ff <= 1'b0;
         last_valid_ff <= 1'b0;
         last_cjk_ff   <= 1'b0;
         tail_valid_ff <= 1'b0;
         item_cnt_ff   <= 3'd0;
         sidx_ff       <= 2'd0;
      end else if (step_go) begin
         if (final_step) begin
            partial_ff    <= '0;
            rem_ff        <= 2'd0;
            head_sent_ff  <= 1'b0;
            space_pend_ff <= 1'b0;
            last_valid_ff <= 1'b0;
            last_cjk_ff   <= 1'b0;
            tail_valid_ff <= 1'b0;
            item_cnt_ff   <= 3'd0;
            sidx_ff       <= 2'd0;
         end else begin
            partial_ff    <= partial_in;
            rem_ff        <= rem_in;
            head_sent_ff  <= head_sent_in;
            space_pend_ff <= space_pend_in;
            last_valid_ff <= last_valid_in;
            last_cjk_ff   <= last_cjk_in;
            tail_valid_ff <= tail_valid_in;
            item_cnt_ff   <= last_step ? 3'd0 : item_cnt_ff + n_cap;
            sidx_ff       <= last_step ? 2'd0 : sidx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step_go) begin
         tail_ff <= tail_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/usn_emit.sv @@
`timescale 1ns / 1ps
`default_nettype none

module usn_emit (
   input  logic               clock,
   input  logic               reset,
   input  logic               burst_valid,
   input  usn_pkg::burst_type burst,
   output logic               emit_free,
   usn_stream_if.source       rsp_chan
);
   import usn_pkg::*;

   burst_type       hold_ff;
   logic            hold_valid_ff;
   logic [2:0]      idx_ff;
   logic            last_idx;
   logic            taken;
   rsp_payload_type payload;

   assign last_idx       = idx_ff == (hold_ff.count - 3'd1);
   assign taken          = rsp_chan.valid && rsp_chan.ready;
   assign emit_free      = !hold_valid_ff || (rsp_chan.ready && last_idx);
   assign rsp_chan.valid = hold_valid_ff;
   assign rsp_chan.payload = payload;

   always_comb begin
      payload.out_byte    = hold_ff.bare ? 8'h00 : hold_ff.data[idx_ff];
      payload.byte_valid  = !hold_ff.bare;
      payload.end_of_text = hold_ff.eot && last_idx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         idx_ff        <= 3'd0;
      end else if (burst_valid) begin
         hold_valid_ff <= 1'b1;
         idx_ff        <= 3'd0;
      end else if (taken) begin
         if (last_idx) begin
            hold_valid_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (burst_valid) begin
         hold_ff <= burst;
      end
   end

endmodule

`default_nettype wire

@@ hdl/utf8_subword_space_normalizer.sv @@
// Channel    Dir  Payload                                   Handshake
// req_chan   in   in_byte[7:0], text_end                    valid / ready
// rsp_chan   out  out_byte[7:0], byte_valid, end_of_text    valid / ready
//
// An item is taken in any cycle in which the decode queue (QUEUE_DEPTH entries) has room.
// Each byte an item hands the decoder (zero to three) takes one decode step, which waits until the emitter
// is empty or is handing out the last result of the step before; the first result appears in the cycle after.
// Reset is synchronous and clears all control state.
// A stall on rsp_chan holds the result register and backs up through the decoder into the
// queue; req_chan.ready drops only when the queue is full.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module utf8_subword_space_normalizer #(
   parameter int QUEUE_DEPTH = usn_pkg::QueueDepth
) (
   input logic          clock,
   input logic          reset,
   usn_stream_if.sink   req_chan,
   usn_stream_if.source rsp_chan
);
   import usn_pkg::*;

   logic          q_full;
   logic          q_push;
   dec_entry_type q_push_data;
   logic          q_pop;
   dec_entry_type q_pop_data;
   logic          q_not_empty;
   logic          emit_free;
   logic          burst_valid;
   burst_type     burst;
   logic          out_bare;
   logic          out_bare_ok;
   logic          end_accept;

   usn_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (q_full),
      .push       (q_push),
      .entry      (q_push_data)
   );

   usn_fifo #(
      .Depth (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .not_empty (q_not_empty)
   );

   usn_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .entry       (q_pop_data),
      .entry_valid (q_not_empty),
      .entry_pop   (q_pop),
      .emit_free   (emit_free),
      .burst_valid (burst_valid),
      .burst       (burst)
   );

   usn_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .burst_valid (burst_valid),
      .burst       (burst),
      .emit_free   (emit_free),
      .rsp_chan    (rsp_chan)
   );

   assign out_bare    = rsp_chan.valid && !rsp_chan.payload.byte_valid;
   assign out_bare_ok = rsp_chan.payload.end_of_text && rsp_chan.payload.out_byte == 8'h00;
   assign end_accept  = req_chan.valid && req_chan.ready && req_chan.payload.text_end;

   `USN_ASSERT_IMPLY(a_bare_is_end, clock, reset, out_bare, out_bare_ok, "bare result without end")
   `USN_ASSERT_IMPLY(a_no_load_when_busy, clock, reset, !emit_free, !burst_valid, "load while busy")
   `USN_ASSERT_NEXT(a_end_item_queued, clock, reset, end_accept, q_not_empty, "end item not queued")

endmodule

`default_nettype wire
